>>> design/mmts_pkg.sv
// Shared types and constants of the multi-mode timer scheduler.
// Depends on nothing; every other design file imports it.
package mmts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int KIND_W = 2;
  localparam int TT_W   = 2;
  localparam int TIME_W = 32;
  localparam int DL_W   = TIME_W + 1;
  localparam int SEL_W  = 4;
  localparam int THR_W  = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REG  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_COND = 2'd2
  } kind_e;

  typedef enum logic [TT_W-1:0] {
    TT_ONESHOT  = 2'd0,
    TT_PERIODIC = 2'd1,
    TT_UNTIL    = 2'd2,
    TT_WHILE    = 2'd3
  } tt_e;

  typedef struct packed {
    tt_e               kind;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last_fire;
  } entry_t;

  typedef struct packed {
    logic             fired;
    logic [SEL_W-1:0] fired_slot;
    logic             removed;
    logic             late;
    logic             accepted;
    logic [SEL_W-1:0] new_slot;
    logic             full_res;
  } res_t;

endpackage

>>> design/mmts_if.sv
// Valid/ready channel interfaces for the timer scheduler's request and result words.
// Depends on mmts_pkg for field widths.
interface mmts_in_if import mmts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TT_W-1:0]   timer_type;
  logic [TIME_W-1:0] time_point;
  logic [TIME_W-1:0] period;
  logic [SEL_W-1:0]  slot_select;
  logic              condition;

  modport source (output valid, kind, timer_type, time_point, period, slot_select, condition,
                  input ready);
  modport sink   (input valid, kind, timer_type, time_point, period, slot_select, condition,
                  output ready);
endinterface

interface mmts_out_if import mmts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             fired;
  logic [SEL_W-1:0] fired_slot;
  logic             removed;
  logic             late;
  logic             accepted;
  logic [SEL_W-1:0] new_slot;
  logic             full_res;

  modport source (output valid, fired, fired_slot, removed, late, accepted, new_slot, full_res,
                  input ready);
  modport sink   (input valid, fired, fired_slot, removed, late, accepted, new_slot, full_res,
                  output ready);
endinterface

>>> design/multi_mode_timer_scheduler.sv
// Multi-mode timer scheduler: earliest-deadline timer selection over SLOTS slots.
// Tick word: the slot scan reads one entry per cycle into its deadline and compare stages,
//   then decide and apply act on the earliest timer if due. One word in work at a time.
// Register words pass through the register state; condition and unused-kind words do not.
// A finished result waits in the output register while the next word is taken.
// Reset (async, active low): no slot valid, all condition flags 1, tick counter 0, threshold 10.
module multi_mode_timer_scheduler import mmts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  mmts_in_if.sink          req_i,
  mmts_out_if.source       rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_SCAN,
    ST_DECIDE,
    ST_APPLY,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration and global time
  logic [THR_W-1:0]  thr_q;
  logic [TIME_W-1:0] now_q;

  // Per-slot flags live in flops: valid bits clear at reset, condition flags set.
  logic [SLOTS-1:0] slot_valid_q;
  logic [SLOTS-1:0] slot_cond_q;

  // Timer descriptors live in a one-port-write, one-port-read memory, undefined until written.
  entry_t slot_mem_q [SLOTS];
  entry_t rd_data_q;

  // Latched request word
  logic [TT_W-1:0]   ttype_q;
  logic [TIME_W-1:0] tp_q;
  logic [TIME_W-1:0] per_q;

  // Scan pipeline: read issue, deadline stage, compare stage
  logic [CNT_W-1:0] scan_cnt_q;
  logic             p1_v_q;
  slot_idx_t        p1_idx_q;
  logic             p2_v_q;
  slot_idx_t        p2_idx_q;
  logic [DL_W-1:0]  p2_dl_q;
  entry_t           p2_ent_q;

  // Best candidate so far
  logic             best_v_q;
  slot_idx_t        best_idx_q;
  logic [DL_W-1:0]  best_dl_q;
  entry_t           best_ent_q;

  // Decision of the handled timer
  logic              due_q;
  logic              end_hit_q;
  logic [TIME_W-1:0] late_amt_q;

  // Result held for the output stage, and the output register itself
  res_t res_q;
  res_t out_q;
  logic out_v_q;

  // Combinational helpers
  logic            mem_re;
  slot_idx_t       mem_raddr;
  logic            mem_we;
  slot_idx_t       mem_waddr;
  entry_t          mem_wdata;
  logic            free_found;
  slot_idx_t       free_idx;
  logic [DL_W-1:0] dl_new;
  logic            ap_fired;
  logic            ap_removed;
  logic            ap_upd;

  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.fired      = out_q.fired;
  assign rsp_o.fired_slot = out_q.fired_slot;
  assign rsp_o.removed    = out_q.removed;
  assign rsp_o.late       = out_q.late;
  assign rsp_o.accepted   = out_q.accepted;
  assign rsp_o.new_slot   = out_q.new_slot;
  assign rsp_o.full_res   = out_q.full_res;

  // Lowest free slot for a register word.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = slot_idx_t'(i);
      end
    end
  end

  // Deadline of the entry just read: end time for one-shot, else last fire plus period, no wrap.
  always_comb begin
    if (rd_data_q.kind == TT_ONESHOT) begin
      dl_new = {1'b0, rd_data_q.end_time};
    end else begin
      dl_new = {1'b0, rd_data_q.last_fire} + {1'b0, rd_data_q.period};
    end
  end

  // Action on the selected due timer.
  always_comb begin
    ap_fired   = 1'b0;
    ap_removed = 1'b0;
    ap_upd     = 1'b0;
    case (best_ent_q.kind)
      TT_ONESHOT: begin
        ap_fired   = 1'b1;
        ap_removed = 1'b1;
      end
      TT_PERIODIC: begin
        ap_fired = 1'b1;
        ap_upd   = 1'b1;
      end
      TT_UNTIL: begin
        // At or past its end time the timer leaves without firing.
        ap_upd     = 1'b1;
        ap_removed = end_hit_q;
        ap_fired   = !end_hit_q;
      end
      default: begin
        ap_fired   = 1'b1;
        ap_upd     = slot_cond_q[best_idx_q];
        ap_removed = !slot_cond_q[best_idx_q];
      end
    endcase
  end

  // Memory port control. Writes only happen in ST_REG and ST_APPLY and reads only in ST_SCAN;
  // one word is in work at a time, so a write always lands before the next scan reads it.
  always_comb begin
    mem_re    = (state_q == ST_SCAN) && (scan_cnt_q < CNT_W'(SLOTS));
    mem_raddr = scan_cnt_q[SLOT_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = '{kind: tt_e'(ttype_q), end_time: tp_q, period: per_q, last_fire: now_q};
    if (state_q == ST_REG) begin
      mem_we = free_found;
    end else if (state_q == ST_APPLY) begin
      mem_we              = due_q && ap_upd;
      mem_waddr           = best_idx_q;
      mem_wdata           = best_ent_q;
      mem_wdata.last_fire = now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= slot_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      thr_q        <= THR_RESET;
      now_q        <= '0;
      slot_valid_q <= '0;
      slot_cond_q  <= '1;
      ttype_q      <= '0;
      tp_q         <= '0;
      per_q        <= '0;
      scan_cnt_q   <= '0;
      p1_v_q       <= 1'b0;
      p1_idx_q     <= '0;
      p2_v_q       <= 1'b0;
      p2_idx_q     <= '0;
      p2_dl_q      <= '0;
      p2_ent_q     <= '0;
      best_v_q     <= 1'b0;
      best_idx_q   <= '0;
      best_dl_q    <= '0;
      best_ent_q   <= '0;
      due_q        <= 1'b0;
      end_hit_q    <= 1'b0;
      late_amt_q   <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // Load a finished result once the output register is free, else drop a taken one.
      if ((state_q == ST_DONE) && (!out_v_q || rsp_o.ready)) begin
        out_q   <= res_q;
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            ttype_q <= req_i.timer_type;
            tp_q    <= req_i.time_point;
            per_q   <= req_i.period;
            res_q   <= '0;
            if (req_i.kind == KIND_TICK) begin
              // Advance time first, then scan against the new time.
              now_q      <= now_q + TIME_W'(1);
              scan_cnt_q <= '0;
              best_v_q   <= 1'b0;
              state_q    <= ST_SCAN;
            end else if (req_i.kind == KIND_REG) begin
              state_q <= ST_REG;
            end else begin
              if ((req_i.kind == KIND_COND) && (32'(req_i.slot_select) < 32'(SLOTS))) begin
                slot_cond_q[slot_idx_t'(req_i.slot_select)] <= req_i.condition;
              end
              state_q <= ST_DONE;
            end
          end
        end

        ST_REG: begin
          if (free_found) begin
            slot_valid_q[free_idx] <= 1'b1;
            slot_cond_q[free_idx]  <= 1'b1;
            res_q.accepted         <= 1'b1;
            res_q.new_slot         <= SEL_W'(free_idx);
          end else begin
            res_q.full_res <= 1'b1;
          end
          state_q <= ST_DONE;
        end

        ST_SCAN: begin
          if (mem_re) begin
            scan_cnt_q <= scan_cnt_q + CNT_W'(1);
          end
          p1_v_q   <= mem_re;
          p1_idx_q <= mem_raddr;
          p2_v_q   <= p1_v_q && slot_valid_q[p1_idx_q];
          p2_idx_q <= p1_idx_q;
          p2_dl_q  <= dl_new;
          p2_ent_q <= rd_data_q;
          // Strict compare in slot order keeps the lowest slot on a tie.
          if (p2_v_q && (!best_v_q || (p2_dl_q < best_dl_q))) begin
            best_v_q   <= 1'b1;
            best_idx_q <= p2_idx_q;
            best_dl_q  <= p2_dl_q;
            best_ent_q <= p2_ent_q;
          end
          if (!mem_re && !p1_v_q && !p2_v_q) begin
            state_q <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          due_q      <= best_v_q && (best_dl_q <= {1'b0, now_q});
          late_amt_q <= TIME_W'({1'b0, now_q} - best_dl_q);
          end_hit_q  <= (now_q >= best_ent_q.end_time);
          state_q    <= ST_APPLY;
        end

        ST_APPLY: begin
          if (due_q) begin
            res_q.fired      <= ap_fired;
            res_q.fired_slot <= SEL_W'(best_idx_q);
            res_q.removed    <= ap_removed;
            res_q.late       <= (late_amt_q > TIME_W'(thr_q));
            if (ap_removed) begin
              slot_valid_q[best_idx_q] <= 1'b0;
            end
          end
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          // Hold the result until the output register frees up.
          if (!out_v_q || rsp_o.ready) begin
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A removed timer no longer occupies its slot.
  a_remove_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) && due_q && ap_removed |=> !slot_valid_q[$past(best_idx_q)])
    else $error("removed timer still marked valid");

  // A stored register word occupies the slot it was given.
  a_reg_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REG) && free_found |=> slot_valid_q[$past(free_idx)])
    else $error("registered slot not marked valid");

  // Time moves by exactly one on each accepted tick word.
  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && (req_i.kind == KIND_TICK)
      |=> now_q == TIME_W'($past(now_q) + TIME_W'(1)))
    else $error("tick counter did not advance by one");

  // A result word never mixes register outcomes with timer handling.
  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(out_q.accepted && out_q.full_res) &&
                !((out_q.fired || out_q.removed) && (out_q.accepted || out_q.full_res)))
    else $error("result word mixes register and tick outcomes");

endmodule

>>> bench/multi_mode_timer_scheduler_tb.sv
// Self-checking bench for multi_mode_timer_scheduler: directed table, then random phases.
// Depends on mmts_pkg, the mmts_in_if / mmts_out_if channels and the scheduler itself.
`timescale 1ns / 100ps

module multi_mode_timer_scheduler_tb;
  import mmts_pkg::*;

  // Kind value 3 has no meaning; the block must ignore it.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off that backs the block up
  localparam int LAT_PAD     = 40;    // settle pad after draining, well beyond a tick word's work
  localparam int IDLE_LIMIT  = 3000;  // cycles without any handshake before giving up
  localparam int PHASE_WORDS = 245;
  localparam int N_PHASES    = 4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    tt_e               ttype;
    logic [TIME_W-1:0] tp;
    logic [TIME_W-1:0] per;
    logic [SEL_W-1:0]  sel;
    logic              cond;
  } word_t;

  // One row of the directed table: the word, whether a typed result is given, that result.
  typedef struct packed {
    word_t w;
    logic  given;
    res_t  r;
  } dir_row_t;

  // Result fields in port order: fired, fired_slot, removed, late, accepted, new_slot, full_res.
  localparam res_t R_NONE = '0;

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // empty scheduler: a tick hands nothing
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1, R_NONE},
    // spare kind with every field at its top value: ignored
    '{'{KIND_SPARE, TT_WHILE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1}, 1'b1, R_NONE},
    // condition flags on unused slots are stored silently
    '{'{KIND_COND, TT_ONESHOT, 32'h0, 32'h0, 4'd15, 1'b0}, 1'b1, R_NONE},
    '{'{KIND_COND, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1, R_NONE},
    // one-shot in the past lands in slot 0, fires and leaves on the next tick
    '{'{KIND_REG, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 4'd0, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0}},
    // periodic with the largest period: never due
    '{'{KIND_REG, TT_PERIODIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
    '{'{KIND_REG, TT_UNTIL, 32'd5, 32'd1, 4'd0, 1'b0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 4'd1, 1'b0}},
    '{'{KIND_REG, TT_WHILE, 32'h0, 32'd2, 4'd0, 1'b0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 4'd2, 1'b0}},
    // ticks with a deadline tie between slots 1 and 2
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    // drop the while-condition of slot 2
    '{'{KIND_COND, TT_ONESHOT, 32'h0, 32'h0, 4'd2, 1'b0}, 1'b1, R_NONE},
    // until-end timer reaches its end and leaves quietly, then the while timer leaves
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    // two one-shots with equal deadlines: lowest slot first
    '{'{KIND_REG, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_REG, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    // while timer with zero period, kept once, then removed after its flag drops
    '{'{KIND_REG, TT_WHILE, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    '{'{KIND_COND, TT_ONESHOT, 32'h0, 32'h0, 4'd1, 1'b0}, 1'b1, R_NONE},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b0, R_NONE},
    // one-shot twelve ticks overdue: late against the reset threshold of 10
    '{'{KIND_REG, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 4'd1, 1'b0}},
    '{'{KIND_TICK, TT_ONESHOT, 32'h0, 32'h0, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 4'd1, 1'b1, 1'b1, 1'b0, 4'd0, 1'b0}}
  };

  // Per-phase threshold and word mix (percent register, tick, condition; rest spare kind).
  localparam int PH_THR  [N_PHASES] = '{0, 65535, -1, 5};
  localparam int PH_REG  [N_PHASES] = '{25, 55, 25, 15};
  localparam int PH_TICK [N_PHASES] = '{60, 30, 60, 75};
  localparam int PH_COND [N_PHASES] = '{12, 12, 12, 8};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [THR_W-1:0] cfg_wdata_i;

  mmts_in_if  req ();
  mmts_out_if rsp ();

  multi_mode_timer_scheduler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  always #5 clk_i = ~clk_i;

  // Scheduler state as the bench believes it to be.
  logic [TIME_W-1:0] tick_now;
  logic [THR_W-1:0]  late_limit;
  logic              slot_used [SLOTS];
  tt_e               slot_type [SLOTS];
  logic [TIME_W-1:0] slot_end  [SLOTS];
  logic [TIME_W-1:0] slot_per  [SLOTS];
  logic [TIME_W-1:0] slot_last [SLOTS];
  logic              slot_cond [SLOTS];

  res_t pending_results [$];
  int   mismatch_count = 0;
  int   idle_cycles = 0;
  bit   calm = 1'b0;      // no gaps on either side while set
  bit   hold_req = 1'b0;  // ask the receiver for one long hold-off

  // Deadline of a live slot, one bit wider than the counter so it never wraps.
  function automatic logic [DL_W-1:0] slot_deadline(input int s);
    if (slot_type[s] == TT_ONESHOT) return {1'b0, slot_end[s]};
    return {1'b0, slot_last[s]} + {1'b0, slot_per[s]};
  endfunction

  // Apply one accepted word to the believed state and return the result it must produce.
  function automatic res_t predict_word(input word_t w);
    res_t            r;
    int              best;
    logic [DL_W-1:0] dl;
    logic [DL_W-1:0] best_dl;
    r       = '0;
    best    = -1;
    best_dl = '0;
    case (w.kind)
      KIND_REG: begin
        for (int s = 0; s < SLOTS; s++) if (!slot_used[s] && best < 0) best = s;
        if (best < 0) begin
          r.full_res = 1'b1;
        end else begin
          slot_used[best] = 1'b1;
          slot_type[best] = w.ttype;
          slot_end[best]  = w.tp;
          slot_per[best]  = w.per;
          slot_last[best] = tick_now;
          slot_cond[best] = 1'b1;
          r.accepted      = 1'b1;
          r.new_slot      = SEL_W'(best);
        end
      end
      KIND_TICK: begin
        tick_now = tick_now + 1'b1;
        // earliest deadline wins, strict compare keeps the lowest slot on a tie
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_used[s]) begin
            dl = slot_deadline(s);
            if (best < 0 || dl < best_dl) begin
              best    = s;
              best_dl = dl;
            end
          end
        end
        if (best >= 0 && best_dl <= {1'b0, tick_now}) begin
          r.fired_slot = SEL_W'(best);
          r.late       = ({1'b0, tick_now} - best_dl) > DL_W'(late_limit);
          case (slot_type[best])
            TT_ONESHOT: begin
              r.fired   = 1'b1;
              r.removed = 1'b1;
            end
            TT_PERIODIC: begin
              r.fired         = 1'b1;
              slot_last[best] = tick_now;
            end
            TT_UNTIL: begin
              // at or past the end time the timer leaves without a callback
              slot_last[best] = tick_now;
              if (tick_now >= slot_end[best]) r.removed = 1'b1;
              else r.fired = 1'b1;
            end
            default: begin
              r.fired = 1'b1;
              if (slot_cond[best]) slot_last[best] = tick_now;
              else r.removed = 1'b1;
            end
          endcase
          if (r.removed) slot_used[best] = 1'b0;
        end
      end
      KIND_COND: begin
        if (w.sel < SLOTS) slot_cond[w.sel] = w.cond;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Draw a random word, steered by the believed state so that timers come due and leave.
  function automatic word_t draw_word(input int p_reg, input int p_tick, input int p_cond);
    word_t       w;
    int          roll;
    int          lived;
    int unsigned back;
    int          live_while [$];
    w.kind  = KIND_SPARE;
    w.ttype = tt_e'($urandom_range(0, 3));
    w.tp    = $urandom;
    w.per   = $urandom;
    w.sel   = SEL_W'($urandom);
    w.cond  = 1'($urandom_range(0, 1));
    lived   = 0;
    // count slots that will hold on for a long time, so they cannot choke the table
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_used[s]) begin
        if (slot_type[s] == TT_PERIODIC || slot_deadline(s) > {1'b0, tick_now} + 1000 ||
            (slot_type[s] == TT_UNTIL && {1'b0, slot_end[s]} > {1'b0, tick_now} + 1000))
          lived++;
        if (slot_type[s] == TT_WHILE) live_while.insert(live_while.size(), s);
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < p_reg) begin
      w.kind = KIND_REG;
      // now and then keep the raw random times; otherwise stay close to the counter
      if (!(lived < 4 && $urandom_range(0, 99) < 4)) begin
        back = (tick_now < 20) ? tick_now : 20;
        case ($urandom_range(0, (lived < 4) ? 3 : 2))
          0: begin
            w.ttype = TT_ONESHOT;
            w.tp    = tick_now + TIME_W'($urandom_range(0, 30)) -
                      TIME_W'($urandom_range(0, back));
          end
          1: begin
            w.ttype = TT_UNTIL;
            w.per   = TIME_W'($urandom_range(0, 8));
            w.tp    = tick_now + TIME_W'($urandom_range(0, 60));
          end
          2: begin
            w.ttype = TT_WHILE;
            w.per   = TIME_W'($urandom_range(0, 10));
          end
          default: begin
            w.ttype = TT_PERIODIC;
            w.per   = TIME_W'($urandom_range(1, 12));
          end
        endcase
      end
    end else if (roll < p_reg + p_tick) begin
      w.kind = KIND_TICK;
    end else if (roll < p_reg + p_tick + p_cond) begin
      w.kind = KIND_COND;
      // aim half of the flag words at live while-timers
      if (live_while.size() > 0 && $urandom_range(0, 1) == 1)
        w.sel = SEL_W'(live_while[$urandom_range(0, live_while.size() - 1)]);
    end
    return w;
  endfunction

  // Offer one word after a gap, hold it until taken, then record its result.
  task automatic drive_word(input word_t w, input int gap, input logic use_given,
                            input res_t given);
    res_t pred;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.kind        <= w.kind;
    req.timer_type  <= w.ttype;
    req.time_point  <= w.tp;
    req.period      <= w.per;
    req.slot_select <= w.sel;
    req.condition   <= w.cond;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    pred = predict_word(w);
    pending_results.insert(pending_results.size(), use_given ? given : pred);
  endtask

  // Stop offering, let every result come back, then give the block time to settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LAT_PAD) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Stimulus: reset, directed table, then the random phases with a threshold each.
  initial begin
    int    gap;
    int    thr;
    word_t w;
    req.valid       <= 1'b0;
    req.kind        <= '0;
    req.timer_type  <= TT_ONESHOT;
    req.time_point  <= '0;
    req.period      <= '0;
    req.slot_select <= '0;
    req.condition   <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    tick_now   = '0;
    late_limit = THR_RESET;
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 1'b0;
      slot_type[s] = TT_ONESHOT;
      slot_end[s]  = '0;
      slot_per[s]  = '0;
      slot_last[s] = '0;
      slot_cond[s] = 1'b1;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      gap = $urandom_range(0, 7);
      drive_word(DIR_TAB[i].w, gap, DIR_TAB[i].given, DIR_TAB[i].r);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      thr = (PH_THR[ph] < 0) ? $urandom_range(1, 40) : PH_THR[ph];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= THR_W'(thr);
      @(posedge clk_i);
      cfg_we_i   <= 1'b0;
      late_limit = THR_W'(thr);
      // third phase runs back to back and carries the long receiver hold-off
      calm     = (ph == 2);
      hold_req = (ph == 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w   = draw_word(PH_REG[ph], PH_TICK[ph], PH_COND[ph]);
        gap = calm ? 0 : $urandom_range(0, 7);
        drive_word(w, gap, 1'b0, R_NONE);
      end
    end
    drain();

    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls per word, one long hold-off on request, check every result.
  initial begin
    int   stall;
    res_t got;
    res_t want;
    rsp.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (rsp.valid !== 1'b1);
      got = '{rsp.fired, rsp.fired_slot, rsp.removed, rsp.late, rsp.accepted, rsp.new_slot,
              rsp.full_res};
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("fired", 32'(want.fired), 32'(got.fired));
        check_field("fired_slot", 32'(want.fired_slot), 32'(got.fired_slot));
        check_field("removed", 32'(want.removed), 32'(got.removed));
        check_field("late", 32'(want.late), 32'(got.late));
        check_field("accepted", 32'(want.accepted), 32'(got.accepted));
        check_field("new_slot", 32'(want.new_slot), 32'(got.new_slot));
        check_field("full_res", 32'(want.full_res), 32'(got.full_res));
      end
    end
  end

  // Watchdog: give up once no word has moved on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

>>> sim.f
design/mmts_pkg.sv
design/mmts_if.sv
design/multi_mode_timer_scheduler.sv
bench/multi_mode_timer_scheduler_tb.sv
